>>> design/cpu6502_branch_jump_unit_assert.svh
// Assertion macros for the 6502 branch and jump unit
`ifndef CPU6502_BRANCH_JUMP_UNIT_ASSERT_SVH
`define CPU6502_BRANCH_JUMP_UNIT_ASSERT_SVH

// same-cycle implication, ignored while in reset
`define CJB_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, ignored while in reset
`define CJB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication that also covers the reset itself
`define CJB_ASSERT_RST(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/cjb_pkg.sv
// Types and constants shared by the branch and jump unit
package cjb_pkg;

  // command codes
  localparam logic [1:0] CMD_INSTR = 2'd0;
  localparam logic [1:0] CMD_NMI   = 2'd1;
  localparam logic [1:0] CMD_RESET = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_NMI_VEC   = 2'd0;
  localparam logic [1:0] REG_RESET_VEC = 2'd1;
  localparam logic [1:0] REG_BRK_VEC   = 2'd2;

  // opcodes
  localparam logic [7:0] OPC_BRK     = 8'h00;
  localparam logic [7:0] OPC_JSR     = 8'h20;
  localparam logic [7:0] OPC_RTI     = 8'h40;
  localparam logic [7:0] OPC_JMP_ABS = 8'h4C;
  localparam logic [7:0] OPC_RTS     = 8'h60;
  localparam logic [7:0] OPC_JMP_IND = 8'h6C;
  localparam logic [4:0] OPC_BRANCH_LOW = 5'h10;

  // status flags
  localparam logic [7:0] FLAG_I = 8'h04;
  localparam logic [7:0] FLAG_B = 8'h10;
  localparam logic [7:0] FLAG_U = 8'h20;

  localparam logic [7:0] SP_RESET = 8'hFD;
  localparam logic [7:0] SP_ADJ_RTS   = 8'h02;
  localparam logic [7:0] SP_ADJ_RTI   = 8'h03;
  localparam logic [7:0] SP_ADJ_RESET = 8'hFD;   // minus three

  // cycle costs
  localparam logic [2:0] CYC_NONE    = 3'd0;
  localparam logic [2:0] CYC_BR_NOT  = 3'd2;
  localparam logic [2:0] CYC_BR_SAME = 3'd3;
  localparam logic [2:0] CYC_BR_PAGE = 3'd4;
  localparam logic [2:0] CYC_JMP_ABS = 3'd3;
  localparam logic [2:0] CYC_JMP_IND = 3'd5;
  localparam logic [2:0] CYC_SUB     = 3'd6;
  localparam logic [2:0] CYC_INT     = 3'd7;

  localparam logic [1:0] PUSH_CALL = 2'd2;
  localparam logic [1:0] PUSH_INT  = 2'd3;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_BRANCH,
    OP_FLOW,    // PC from word, SP adjusted
    OP_CALL,
    OP_BRK,
    OP_NMI
  } op_kind_t;

  // decoded item handed from front to back
  typedef struct packed {
    op_kind_t   kind;
    logic       taken;
    logic [7:0] offset;
    logic [15:0] word;
    logic [7:0] sp_adj;
    logic [7:0] status;
    logic [7:0] push3;
    logic [2:0] cycles;
  } op_t;

  typedef struct packed {
    logic       write_valid;
    logic [8:0] write_address;
    logic [7:0] write_data;
    logic       handled;
    logic [15:0] next_pc;
    logic [7:0] stack_pointer_out;
    logic [7:0] status_out;
    logic [2:0] cycles_used;
    logic       last;
  } res_t;

endpackage

>>> design/cjb_fifo.sv
// Small synchronous queue used between front and back and at the output
module cjb_fifo #(
  parameter type T     = logic,
  parameter int  DEPTH = 2
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  T     wdata,
  output logic full,
  input  logic pop,
  output T     rdata,
  output logic empty
);
  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  T              mem [DEPTH];
  logic [AW-1:0] wr_ptr_r;
  logic [AW-1:0] rd_ptr_r;
  logic [CW-1:0] count_r;
  logic          do_push;
  logic          do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end
endmodule

>>> design/cjb_front.sv
// Front end: vector registers and classification of incoming items
module cjb_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_we,
  input  logic [1:0]    cfg_index,
  input  logic [15:0]   cfg_data,
  input  logic [1:0]    in_cmd,
  input  logic [7:0]    in_opcode,
  input  logic [7:0]    in_operand_low,
  input  logic [7:0]    in_operand_high,
  input  logic [7:0]    in_status_in,
  input  logic [15:0]   in_indirect_target,
  input  logic [7:0]    in_stack_first,
  input  logic [7:0]    in_stack_second,
  input  logic [7:0]    in_stack_third,
  output cjb_pkg::op_t  op
);
  import cjb_pkg::*;

  logic [15:0] nmi_vec_r;
  logic [15:0] reset_vec_r;
  logic [15:0] brk_vec_r;
  logic        flag_set;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nmi_vec_r   <= '0;
      reset_vec_r <= '0;
      brk_vec_r   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_NMI_VEC:   nmi_vec_r   <= cfg_data;
        REG_RESET_VEC: reset_vec_r <= cfg_data;
        REG_BRK_VEC:   brk_vec_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // N, V, C, Z selected by the top two opcode bits
  always_comb begin
    unique case (in_opcode[7:6])
      2'd0:    flag_set = in_status_in[7];
      2'd1:    flag_set = in_status_in[6];
      2'd2:    flag_set = in_status_in[0];
      default: flag_set = in_status_in[1];
    endcase
  end

  always_comb begin
    op        = '0;
    op.kind   = OP_NONE;
    op.offset = in_operand_low;
    op.status = in_status_in;
    op.taken  = in_opcode[5] ? flag_set : !flag_set;
    op.cycles = CYC_NONE;
    unique case (in_cmd)
      CMD_NMI: begin
        op.kind   = OP_NMI;
        op.word   = nmi_vec_r;
        op.push3  = (in_status_in & ~FLAG_B) | FLAG_U;
        op.status = in_status_in | FLAG_I;
        op.cycles = CYC_INT;
      end
      CMD_RESET: begin
        op.kind   = OP_FLOW;
        op.word   = reset_vec_r;
        op.sp_adj = SP_ADJ_RESET;
        op.status = in_status_in | FLAG_I;
        op.cycles = CYC_INT;
      end
      CMD_INSTR: begin
        if (in_opcode[4:0] == OPC_BRANCH_LOW) begin
          op.kind = OP_BRANCH;
        end else begin
          unique case (in_opcode)
            OPC_JMP_ABS: begin
              op.kind   = OP_FLOW;
              op.word   = {in_operand_high, in_operand_low};
              op.cycles = CYC_JMP_ABS;
            end
            OPC_JMP_IND: begin
              op.kind   = OP_FLOW;
              op.word   = in_indirect_target;
              op.cycles = CYC_JMP_IND;
            end
            OPC_JSR: begin
              op.kind   = OP_CALL;
              op.word   = {in_operand_high, in_operand_low};
              op.cycles = CYC_SUB;
            end
            OPC_RTS: begin
              op.kind   = OP_FLOW;
              op.word   = {in_stack_second, in_stack_first} + 16'd1;
              op.sp_adj = SP_ADJ_RTS;
              op.cycles = CYC_SUB;
            end
            OPC_RTI: begin
              op.kind   = OP_FLOW;
              op.word   = {in_stack_third, in_stack_second};
              op.sp_adj = SP_ADJ_RTI;
              op.status = (in_stack_first & ~FLAG_B) | FLAG_U;
              op.cycles = CYC_SUB;
            end
            OPC_BRK: begin
              op.kind   = OP_BRK;
              op.word   = brk_vec_r;
              op.push3  = in_status_in | FLAG_B | FLAG_U;
              op.status = in_status_in | FLAG_I;
              op.cycles = CYC_INT;
            end
            default: op.kind = OP_NONE;
          endcase
        end
      end
      default: op.kind = OP_NONE;
    endcase
  end
endmodule

>>> design/cjb_back.sv
// Back end: PC and SP state, branch targets and stack pushes
module cjb_back (
  input  logic          clk,
  input  logic          rst_n,
  input  cjb_pkg::op_t  op,
  input  logic          op_empty,
  output logic          op_pop,
  input  logic          res_full,
  output logic          res_push,
  output cjb_pkg::res_t res
);
  import cjb_pkg::*;

  logic [15:0] pc_r;
  logic [7:0]  sp_r;
  logic [1:0]  step_r;

  logic        issue;
  logic [1:0]  npush;
  logic        is_push;
  logic [15:0] ret_addr;
  logic [15:0] base;
  logic [15:0] target;
  logic [15:0] pc_nxt;
  logic [7:0]  sp_nxt;
  logic [2:0]  cyc;
  logic [7:0]  push_byte;

  assign issue = !op_empty && !res_full;

  always_comb begin
    unique case (op.kind)
      OP_CALL:        npush = PUSH_CALL;
      OP_BRK, OP_NMI: npush = PUSH_INT;
      default:        npush = 2'd0;
    endcase
  end

  assign is_push  = (step_r < npush);
  assign ret_addr = (op.kind == OP_NMI) ? pc_r : pc_r + 16'd2;
  assign base     = pc_r + 16'd2;
  assign target   = base + {{8{op.offset[7]}}, op.offset};

  always_comb begin
    unique case (step_r)
      2'd0:    push_byte = ret_addr[15:8];
      2'd1:    push_byte = ret_addr[7:0];
      default: push_byte = op.push3;
    endcase
  end

  always_comb begin
    pc_nxt = op.word;
    cyc    = op.cycles;
    unique case (op.kind)
      OP_BRANCH: begin
        if (op.taken) begin
          pc_nxt = target;
          cyc    = (target[15:8] != base[15:8]) ? CYC_BR_PAGE : CYC_BR_SAME;
        end else begin
          pc_nxt = base;
          cyc    = CYC_BR_NOT;
        end
      end
      OP_NONE: pc_nxt = pc_r;
      default: ;
    endcase
  end

  // pushing kinds carry a zero adjustment; their decrements happen per push
  assign sp_nxt = sp_r + op.sp_adj;

  always_comb begin
    res = '0;
    if (is_push) begin
      res.write_valid   = 1'b1;
      res.write_address = {1'b1, sp_r};
      res.write_data    = push_byte;
    end else begin
      res.handled           = (op.kind != OP_NONE);
      res.next_pc           = pc_nxt;
      res.stack_pointer_out = sp_nxt;
      res.status_out        = op.status;
      res.cycles_used       = cyc;
      res.last              = 1'b1;
    end
  end

  assign res_push = issue;
  assign op_pop   = issue && !is_push;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r   <= '0;
      sp_r   <= SP_RESET;
      step_r <= '0;
    end else if (issue) begin
      if (is_push) begin
        sp_r   <= sp_r - 8'd1;
        step_r <= step_r + 2'd1;
      end else begin
        pc_r   <= pc_nxt;
        sp_r   <= sp_nxt;
        step_r <= '0;
      end
    end
  end
endmodule

>>> design/cpu6502_branch_jump_unit.sv
// Top level of the 6502 branch, jump and interrupt entry unit
//
//  channel | ports                       | item accepted when
//  --------+-----------------------------+---------------------
//  input   | in_push, in_full, in_*      | in_push && !in_full
//  result  | out_pop, out_empty, out_*   | out_pop && !out_empty
//  config  | cfg_we, cfg_index, cfg_data | cfg_we
//
// With an item queued and output room, the back end emits one result a cycle: one per
// branch, jump, RTS, RTI, reset entry or unhandled item, three per JSR and four per BRK
// or NMI (pushes plus final); an item and its results pass two registered queues.
// Reset (synchronous): PC 0, SP 0xFD, vectors 0, both queues empty.
// A full output queue holds the back end; the command queue takes items until it fills.
module cpu6502_branch_jump_unit #(
  parameter int CMD_DEPTH = 2,   // 2 and up
  parameter int OUT_DEPTH = 2    // 2 and up
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_push,
  output logic        in_full,
  input  logic [1:0]  in_cmd,
  input  logic [7:0]  in_opcode,
  input  logic [7:0]  in_operand_low,
  input  logic [7:0]  in_operand_high,
  input  logic [7:0]  in_status_in,
  input  logic [15:0] in_indirect_target,
  input  logic [7:0]  in_stack_first,
  input  logic [7:0]  in_stack_second,
  input  logic [7:0]  in_stack_third,
  output logic        out_empty,
  input  logic        out_pop,
  output logic        out_write_valid,
  output logic [8:0]  out_write_address,
  output logic [7:0]  out_write_data,
  output logic        out_handled,
  output logic [15:0] out_next_pc,
  output logic [7:0]  out_stack_pointer_out,
  output logic [7:0]  out_status_out,
  output logic [2:0]  out_cycles_used,
  output logic        out_last
);
  import cjb_pkg::*;

  op_t  dec_op;
  op_t  head_op;
  logic cmd_empty;
  logic cmd_pop;
  logic res_full;
  logic res_push;
  res_t res;
  res_t out_res;

  cjb_front u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_cmd             (in_cmd),
    .in_opcode          (in_opcode),
    .in_operand_low     (in_operand_low),
    .in_operand_high    (in_operand_high),
    .in_status_in       (in_status_in),
    .in_indirect_target (in_indirect_target),
    .in_stack_first     (in_stack_first),
    .in_stack_second    (in_stack_second),
    .in_stack_third     (in_stack_third),
    .op                 (dec_op)
  );

  cjb_fifo #(.T(op_t), .DEPTH(CMD_DEPTH)) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_push),
    .wdata (dec_op),
    .full  (in_full),
    .pop   (cmd_pop),
    .rdata (head_op),
    .empty (cmd_empty)
  );

  cjb_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .op       (head_op),
    .op_empty (cmd_empty),
    .op_pop   (cmd_pop),
    .res_full (res_full),
    .res_push (res_push),
    .res      (res)
  );

  cjb_fifo #(.T(res_t), .DEPTH(OUT_DEPTH)) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res),
    .full  (res_full),
    .pop   (out_pop),
    .rdata (out_res),
    .empty (out_empty)
  );

  assign out_write_valid       = out_res.write_valid;
  assign out_write_address     = out_res.write_address;
  assign out_write_data        = out_res.write_data;
  assign out_handled           = out_res.handled;
  assign out_next_pc           = out_res.next_pc;
  assign out_stack_pointer_out = out_res.stack_pointer_out;
  assign out_status_out        = out_res.status_out;
  assign out_cycles_used       = out_res.cycles_used;
  assign out_last              = out_res.last;

`include "cpu6502_branch_jump_unit_assert.svh"

  `CJB_ASSERT_RST(a_reset_empties_out, !rst_n, out_empty, "output queue not empty after reset")
  `CJB_ASSERT_IMP(a_no_push_when_full, res_push, !res_full, "result issued into a full queue")
  `CJB_ASSERT_NEXT(a_accept_queued, in_push && !in_full, !cmd_empty, "accepted item lost")
  `CJB_ASSERT_IMP(a_non_last_is_write, !out_empty && !out_last, out_write_valid, "bad result")

endmodule

>>> bench/cpu6502_branch_jump_unit_test.sv
// Self-checking testbench for the 6502 branch, jump and interrupt entry unit
`timescale 1ns / 100ps

module cpu6502_branch_jump_unit_test;
  import cjb_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam int unsigned PHASE_ITEMS = 70;
  localparam logic [1:0] CMD_SPARE = 2'd3;
  // status bit positions tested by the branches
  localparam int BIT_C = 0;
  localparam int BIT_Z = 1;
  localparam int BIT_V = 6;
  localparam int BIT_N = 7;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [7:0]  opcode;
    logic [7:0]  operand_low;
    logic [7:0]  operand_high;
    logic [7:0]  status;
    logic [15:0] indirect;
    logic [7:0]  stack_first;
    logic [7:0]  stack_second;
    logic [7:0]  stack_third;
  } flow_item_t;

  typedef struct {
    flow_item_t stim;
    bit         typed;
    res_t       fixed;
  } dir_row_t;

  localparam res_t NO_SUMMARY = '0;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic        in_push = 1'b0;
  logic        in_full;
  logic [1:0]  in_cmd = '0;
  logic [7:0]  in_opcode = '0;
  logic [7:0]  in_operand_low = '0;
  logic [7:0]  in_operand_high = '0;
  logic [7:0]  in_status_in = '0;
  logic [15:0] in_indirect_target = '0;
  logic [7:0]  in_stack_first = '0;
  logic [7:0]  in_stack_second = '0;
  logic [7:0]  in_stack_third = '0;
  logic        out_empty;
  logic        out_pop = 1'b0;
  logic        out_write_valid;
  logic [8:0]  out_write_address;
  logic [7:0]  out_write_data;
  logic        out_handled;
  logic [15:0] out_next_pc;
  logic [7:0]  out_stack_pointer_out;
  logic [7:0]  out_status_out;
  logic [2:0]  out_cycles_used;
  logic        out_last;

  // model state
  logic [15:0] model_pc = '0;
  logic [7:0]  model_sp = SP_RESET;
  logic [15:0] vec_nmi = '0;
  logic [15:0] vec_reset = '0;
  logic [15:0] vec_brk = '0;

  res_t        expected_flow_results[$];
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  bit          calm = 1'b0;
  bit          backlog_request = 1'b0;

  cpu6502_branch_jump_unit u_top (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data),
    .in_push              (in_push),
    .in_full              (in_full),
    .in_cmd               (in_cmd),
    .in_opcode            (in_opcode),
    .in_operand_low       (in_operand_low),
    .in_operand_high      (in_operand_high),
    .in_status_in         (in_status_in),
    .in_indirect_target   (in_indirect_target),
    .in_stack_first       (in_stack_first),
    .in_stack_second      (in_stack_second),
    .in_stack_third       (in_stack_third),
    .out_empty            (out_empty),
    .out_pop              (out_pop),
    .out_write_valid      (out_write_valid),
    .out_write_address    (out_write_address),
    .out_write_data       (out_write_data),
    .out_handled          (out_handled),
    .out_next_pc          (out_next_pc),
    .out_stack_pointer_out(out_stack_pointer_out),
    .out_status_out       (out_status_out),
    .out_cycles_used      (out_cycles_used),
    .out_last             (out_last)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic flow_item_t item(logic [1:0] cmd, logic [7:0] opcode, logic [7:0] lo,
                                      logic [7:0] hi, logic [7:0] status, logic [15:0] ind,
                                      logic [7:0] s1, logic [7:0] s2, logic [7:0] s3);
    item = '{cmd, opcode, lo, hi, status, ind, s1, s2, s3};
  endfunction

  function automatic res_t summary(logic handled, logic [15:0] pc, logic [7:0] sp,
                                   logic [7:0] status, logic [2:0] cycles);
    summary = '0;
    summary.handled = handled;
    summary.next_pc = pc;
    summary.stack_pointer_out = sp;
    summary.status_out = status;
    summary.cycles_used = cycles;
    summary.last = 1'b1;
  endfunction

  task automatic queue_stack_push(input logic [7:0] data);
    res_t r;
    r = '0;
    r.write_valid = 1'b1;
    r.write_address = {1'b1, model_sp};
    r.write_data = data;
    expected_flow_results.push_back(r);
    model_sp = model_sp - 8'd1;
  endtask

  task automatic queue_flow_summary(input logic handled, input logic [7:0] status,
                                    input logic [2:0] cycles);
    expected_flow_results.push_back(summary(handled, model_pc, model_sp, status, cycles));
  endtask

  task automatic enter_interrupt(input logic [15:0] ret, input logic [7:0] pushed,
                                 input logic [15:0] vector, input logic [7:0] status);
    queue_stack_push(ret[15:8]);
    queue_stack_push(ret[7:0]);
    queue_stack_push(pushed);
    model_pc = vector;
    queue_flow_summary(1'b1, status | FLAG_I, CYC_INT);
  endtask

  task automatic step_flow_model(input flow_item_t it);
    logic [15:0] base;
    logic [15:0] target;
    logic        flag_set;
    logic        taken;
    case (it.cmd)
      CMD_NMI: enter_interrupt(model_pc, (it.status & ~FLAG_B) | FLAG_U, vec_nmi, it.status);
      CMD_RESET: begin
        model_sp = model_sp - 8'd3;
        model_pc = vec_reset;
        queue_flow_summary(1'b1, it.status | FLAG_I, CYC_INT);
      end
      CMD_INSTR: begin
        if (it.opcode[4:0] == OPC_BRANCH_LOW) begin
          case (it.opcode[7:6])
            2'd0: flag_set = it.status[BIT_N];
            2'd1: flag_set = it.status[BIT_V];
            2'd2: flag_set = it.status[BIT_C];
            default: flag_set = it.status[BIT_Z];
          endcase
          taken = it.opcode[5] ? flag_set : !flag_set;
          base = model_pc + 16'd2;
          target = base + {{8{it.operand_low[7]}}, it.operand_low};
          if (!taken) begin
            model_pc = base;
            queue_flow_summary(1'b1, it.status, CYC_BR_NOT);
          end else begin
            model_pc = target;
            queue_flow_summary(1'b1, it.status,
                               (target[15:8] != base[15:8]) ? CYC_BR_PAGE : CYC_BR_SAME);
          end
        end else begin
          case (it.opcode)
            OPC_JMP_ABS: begin
              model_pc = {it.operand_high, it.operand_low};
              queue_flow_summary(1'b1, it.status, CYC_JMP_ABS);
            end
            OPC_JMP_IND: begin
              model_pc = it.indirect;
              queue_flow_summary(1'b1, it.status, CYC_JMP_IND);
            end
            OPC_JSR: begin
              base = model_pc + 16'd2;
              queue_stack_push(base[15:8]);
              queue_stack_push(base[7:0]);
              model_pc = {it.operand_high, it.operand_low};
              queue_flow_summary(1'b1, it.status, CYC_SUB);
            end
            OPC_RTS: begin
              model_pc = {it.stack_second, it.stack_first} + 16'd1;
              model_sp = model_sp + 8'd2;
              queue_flow_summary(1'b1, it.status, CYC_SUB);
            end
            OPC_RTI: begin
              model_pc = {it.stack_third, it.stack_second};
              model_sp = model_sp + 8'd3;
              queue_flow_summary(1'b1, (it.stack_first & ~FLAG_B) | FLAG_U, CYC_SUB);
            end
            OPC_BRK: enter_interrupt(model_pc + 16'd2, it.status | FLAG_B | FLAG_U, vec_brk,
                                     it.status);
            default: queue_flow_summary(1'b0, it.status, CYC_NONE);
          endcase
        end
      end
      default: queue_flow_summary(1'b0, it.status, CYC_NONE);
    endcase
  endtask

  // mostly legal control flow with random operands, plus some noise
  function automatic flow_item_t random_item();
    flow_item_t  it;
    int unsigned pick;
    logic [95:0] noise;
    noise = {$urandom, $urandom, $urandom};
    it = noise[$bits(flow_item_t)-1:0];
    it.cmd = CMD_INSTR;
    pick = $urandom_range(0, 99);
    if (pick < 45) it.opcode = {3'($urandom_range(0, 7)), OPC_BRANCH_LOW};
    else if (pick < 52) it.opcode = OPC_JMP_ABS;
    else if (pick < 57) it.opcode = OPC_JMP_IND;
    else if (pick < 65) it.opcode = OPC_JSR;
    else if (pick < 72) it.opcode = OPC_RTS;
    else if (pick < 78) it.opcode = OPC_RTI;
    else if (pick < 83) it.opcode = OPC_BRK;
    else if (pick < 88) it.cmd = CMD_NMI;
    else if (pick < 91) it.cmd = CMD_RESET;
    else if (pick < 94) it.cmd = CMD_SPARE;
    return it;
  endfunction

  task automatic write_vectors(input logic [15:0] nmi, input logic [15:0] rst,
                               input logic [15:0] brk);
    cfg_we <= 1'b1;
    cfg_index <= REG_NMI_VEC;
    cfg_data <= nmi;
    vec_nmi = nmi;
    @(negedge clk);
    cfg_index <= REG_RESET_VEC;
    cfg_data <= rst;
    vec_reset = rst;
    @(negedge clk);
    cfg_index <= REG_BRK_VEC;
    cfg_data <= brk;
    vec_brk = brk;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // called at a falling edge; returns at a falling edge
  task automatic send_item(input flow_item_t it, input bit typed, input res_t fixed);
    in_cmd <= it.cmd;
    in_opcode <= it.opcode;
    in_operand_low <= it.operand_low;
    in_operand_high <= it.operand_high;
    in_status_in <= it.status;
    in_indirect_target <= it.indirect;
    in_stack_first <= it.stack_first;
    in_stack_second <= it.stack_second;
    in_stack_third <= it.stack_third;
    in_push <= 1'b1;
    do @(posedge clk); while (in_full);
    step_flow_model(it);
    if (typed) expected_flow_results[expected_flow_results.size() - 1] = fixed;
    @(negedge clk);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_push <= 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
  endtask

  task automatic drain_results();
    in_push <= 1'b0;
    while (expected_flow_results.size() != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  initial begin : item_source
    dir_row_t rows[$];
    // an unhandled opcode, the spare command and reset first, then a tour of every branch and flow opcode
    rows.push_back('{item(CMD_INSTR, 8'hEA, 8'h00, 8'h00, 8'h00, 16'h0000, 8'h00, 8'h00, 8'h00),
                     1'b1, summary(1'b0, 16'h0000, SP_RESET, 8'h00, CYC_NONE)});
    rows.push_back('{item(CMD_SPARE, 8'h4C, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF),
                     1'b1, summary(1'b0, 16'h0000, SP_RESET, 8'hFF, CYC_NONE)});
    rows.push_back('{item(CMD_RESET, 8'h00, 8'h00, 8'h00, 8'h00, 16'h0000, 8'h00, 8'h00, 8'h00),
                     1'b1, summary(1'b1, 16'hFFFC, 8'hFA, FLAG_I, CYC_INT)});
    rows.push_back('{item(CMD_INSTR, OPC_JMP_ABS, 8'hF0, 8'h00, 8'hFF, 16'h0, 8'h0, 8'h0, 8'h0),
                     1'b1, summary(1'b1, 16'h00F0, 8'hFA, 8'hFF, CYC_JMP_ABS)});
    rows.push_back('{item(CMD_INSTR, 8'h10, 8'h7F, 8'h00, 8'h00, 16'h0, 8'h0, 8'h0, 8'h0),
                     1'b0, NO_SUMMARY});
    rows.push_back('{item(CMD_INSTR, 8'h30, 8'h7F, 8'h00, 8'h00, 16'h0, 8'h0, 8'h0, 8'h0),
                     1'b0, NO_SUMMARY});
    rows.push_back('{item(CMD_INSTR, 8'h50, 8'h80, 8'h00, 8'h00, 16'h0, 8'h0, 8'h0, 8'h0),
                     1'b0, NO_SUMMARY});
    rows.push_back('{item(CMD_INSTR, 8'h70, 8'h01, 8'h00, 8'h40, 16'h0, 8'h0, 8'h0, 8'h0),
                     1'b0, NO_SUMMARY});
    rows.push_back('{item(CMD_INSTR, 8'h90, 8'h10, 8'h00, 8'h01, 16'h0, 8'h0, 8'h0, 8'h0),
                     1'b0, NO_SUMMARY});
    rows.push_back('{item(CMD_INSTR, 8'hB0, 8'hFE, 8'h00, 8'h01, 16'h0, 8'h0, 8'h0, 8'h0),
                     1'b0, NO_SUMMARY});
    rows.push_back('{item(CMD_INSTR, 8'hD0, 8'h10, 8'h00, 8'h02, 16'h0, 8'h0, 8'h0, 8'h0),
                     1'b0, NO_SUMMARY});
    rows.push_back('{item(CMD_INSTR, 8'hF0, 8'h00, 8'h00, 8'h02, 16'h0, 8'h0, 8'h0, 8'h0),
                     1'b0, NO_SUMMARY});
    rows.push_back('{item(CMD_INSTR, OPC_JMP_IND, 8'h00, 8'h00, 8'h5A, 16'hFFFE, 8'h0, 8'h0,
                          8'h0), 1'b1, summary(1'b1, 16'hFFFE, 8'hFA, 8'h5A, CYC_JMP_IND)});
    // return address wraps past the top of memory
    rows.push_back('{item(CMD_INSTR, OPC_JSR, 8'h34, 8'h12, 8'h00, 16'h0, 8'h0, 8'h0, 8'h0),
                     1'b0, NO_SUMMARY});
    rows.push_back('{item(CMD_INSTR, OPC_RTS, 8'h00, 8'h00, 8'h81, 16'h0, 8'hFF, 8'hFF, 8'h00),
                     1'b0, NO_SUMMARY});
    rows.push_back('{item(CMD_INSTR, OPC_BRK, 8'h00, 8'h00, 8'h00, 16'h0, 8'h0, 8'h0, 8'h0),
                     1'b0, NO_SUMMARY});
    rows.push_back('{item(CMD_NMI, 8'h00, 8'h00, 8'h00, 8'hFF, 16'h0, 8'h0, 8'h0, 8'h0),
                     1'b0, NO_SUMMARY});
    rows.push_back('{item(CMD_INSTR, OPC_RTI, 8'h00, 8'h00, 8'h00, 16'h0, 8'hFF, 8'h34, 8'h12),
                     1'b0, NO_SUMMARY});
    rows.push_back('{item(CMD_INSTR, OPC_RTI, 8'h00, 8'h00, 8'hFF, 16'h0, 8'h00, 8'hFF, 8'hFF),
                     1'b0, NO_SUMMARY});
    rows.push_back('{item(CMD_INSTR, OPC_JMP_ABS, 8'hFF, 8'hFF, 8'h00, 16'h0, 8'h0, 8'h0, 8'h0),
                     1'b0, NO_SUMMARY});
    rows.push_back('{item(CMD_INSTR, 8'hF0, 8'h00, 8'h00, 8'h02, 16'h0, 8'h0, 8'h0, 8'h0),
                     1'b0, NO_SUMMARY});
    rows.push_back('{item(CMD_INSTR, 8'hD0, 8'h80, 8'h00, 8'h00, 16'h0, 8'h0, 8'h0, 8'h0),
                     1'b0, NO_SUMMARY});
    rows.push_back('{item(CMD_INSTR, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF),
                     1'b0, NO_SUMMARY});
    rows.push_back('{item(CMD_RESET, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF),
                     1'b0, NO_SUMMARY});

    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    write_vectors(16'hFFFF, 16'hFFFC, 16'h0000);
    foreach (rows[i]) send_item(rows[i].stim, rows[i].typed, rows[i].fixed);

    for (int phase = 0; phase < 4; phase++) begin
      drain_results();
      case (phase)
        0: write_vectors(16'h0000, 16'hFFFF, 16'hFFFF);
        1: write_vectors(16'($urandom), 16'($urandom), 16'($urandom));
        2: begin
          write_vectors(16'h8000, 16'h7FFF, 16'h0001);
          backlog_request = 1'b1;
        end
        default: begin
          write_vectors(16'($urandom), 16'($urandom), 16'($urandom));
          calm = 1'b1;
        end
      endcase
      repeat (PHASE_ITEMS) send_item(random_item(), 1'b0, NO_SUMMARY);
    end

    drain_results();
    repeat (20) @(negedge clk);
    if (mismatches == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  initial begin : result_sink
    int unsigned hold;
    while (!rst_n) @(negedge clk);
    forever begin
      hold = 0;
      if (backlog_request) begin
        // long stall so the unit fills up and pushes back on its input
        backlog_request = 1'b0;
        hold = 200;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        hold = $urandom_range(1, 9);
      end
      if (hold != 0) begin
        out_pop <= 1'b0;
        repeat (hold) @(negedge clk);
      end
      out_pop <= 1'b1;
      @(negedge clk);
    end
  end

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    res_t want;
    if (rst_n && out_pop && !out_empty) begin
      if (expected_flow_results.size() == 0) begin
        $error("result item with nothing expected: pc %0h", out_next_pc);
        mismatches++;
      end else begin
        want = expected_flow_results.pop_front();
        check_field("write_valid", 16'(want.write_valid), 16'(out_write_valid));
        check_field("write_address", 16'(want.write_address), 16'(out_write_address));
        check_field("write_data", 16'(want.write_data), 16'(out_write_data));
        check_field("handled", 16'(want.handled), 16'(out_handled));
        check_field("next_pc", want.next_pc, out_next_pc);
        check_field("stack_pointer_out", 16'(want.stack_pointer_out),
                    16'(out_stack_pointer_out));
        check_field("status_out", 16'(want.status_out), 16'(out_status_out));
        check_field("cycles_used", 16'(want.cycles_used), 16'(out_cycles_used));
        check_field("last", 16'(want.last), 16'(out_last));
      end
    end
  end

endmodule

>>> filelist.f
+incdir+design
design/cjb_pkg.sv
design/cjb_fifo.sv
design/cjb_front.sv
design/cjb_back.sv
design/cpu6502_branch_jump_unit.sv
bench/cpu6502_branch_jump_unit_test.sv
